>>> rtl/plir_pkg.sv
package plir_pkg;

    localparam int DEPTH   = 64;
    localparam int VALUE_W = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [VALUE_W-1:0] value_t;

    localparam cnt_t DEPTH_CNT = cnt_t'(DEPTH);

    // Request kinds.
    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [6:0]  position;
        logic [31:0] value_in;
    } req_t;

    typedef struct packed {
        logic [31:0] value_out;
        logic [1:0]  status;
        logic [6:0]  count;
        logic        is_empty;
    } rsp_t;

    typedef struct packed {
        logic   we;
        addr_t  waddr;
        value_t wdata;
        logic   re;
        addr_t  raddr;
    } ram_ctl_t;

endpackage

>>> rtl/positional_list_insert_remove.sv
// Positional list of up to 64 32-bit values, addressed by 1-based position.
// Request channel (req_valid, req_stall, req): a request is taken when
// req_valid is high and req_stall is low. req_type selects read, insert or
// remove at req.position; req.value_in is used by insert only.
// Response channel (rsp_valid, rsp_stall, rsp): one response per request,
// in order, with the value read or removed, a status, and the count and
// empty flag after the request.
// Shifting: an insert at position p moves count - p + 1 entries and a
// remove moves count - p; a read moves none. The shift loop moves one entry
// per cycle through the single list memory (one read, one write).
// Errors (full list, bad position, unknown kind) skip the shift loop.
// A new request is taken in the cycle after the previous response has been
// loaded into the output register, even while it is still stalled.
// Reset empties the list (count zero); memory contents are not cleared.
// While rsp_stall is high the response holds and finished work waits.
module positional_list_insert_remove (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  plir_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output plir_pkg::rsp_t rsp
);

    plir_pkg::ram_ctl_t ram;
    plir_pkg::value_t   rdata;
    plir_pkg::rsp_t     result;
    plir_pkg::rsp_t     rsp_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               done;
    logic               take;

    assign take = !rsp_valid_reg || !rsp_stall;

    plir_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_take  (take),
        .done      (done),
        .result    (result),
        .ram       (ram),
        .rdata     (rdata)
    );

    plir_ram #(
        .WIDTH (plir_pkg::VALUE_W),
        .DEPTH (plir_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram.we),
        .waddr (ram.waddr),
        .wdata (ram.wdata),
        .re    (ram.re),
        .raddr (ram.raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (done && take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && take)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> rtl/plir_ram.sv
module plir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/plir_engine.sv
module plir_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  plir_pkg::req_t     req,
    input  logic               rsp_take,
    output logic               done,
    output plir_pkg::rsp_t     result,
    output plir_pkg::ram_ctl_t ram,
    input  plir_pkg::value_t   rdata
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    plir_pkg::req_t   req_reg, req_next;
    plir_pkg::cnt_t   count_reg, count_next;
    plir_pkg::addr_t  rd_addr_reg, rd_addr_next;
    plir_pkg::addr_t  wr_addr_reg, wr_addr_next;
    plir_pkg::cnt_t   rd_left_reg, rd_left_next;
    logic             wr_pend_reg, wr_pend_next;
    logic             head_pend_reg, head_pend_next;
    logic             up_reg, up_next;
    plir_pkg::value_t value_reg, value_next;
    logic [1:0]       status_reg, status_next;

    logic [6:0]          pos;
    logic                pos_ok_rd;
    logic                pos_ok_ins;
    logic                full;
    plir_pkg::addr_t     pos_addr;

    assign pos        = req_reg.position;
    assign pos_addr   = plir_pkg::addr_t'(pos - 7'd1);
    assign pos_ok_rd  = (pos != 7'd0) && (plir_pkg::cnt_t'(pos) <= count_reg);
    assign pos_ok_ins = (pos != 7'd0)
                        && ({1'b0, pos} <= ({1'b0, count_reg} + 8'd1));
    assign full       = (count_reg == plir_pkg::DEPTH_CNT);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        rd_addr_next   = rd_addr_reg;
        wr_addr_next   = wr_addr_reg;
        rd_left_next   = rd_left_reg;
        wr_pend_next   = wr_pend_reg;
        head_pend_next = head_pend_reg;
        up_next        = up_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        ram            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                value_next     = '0;
                status_next    = plir_pkg::ST_OK;
                head_pend_next = 1'b0;
                wr_pend_next   = 1'b0;
                rd_left_next   = '0;
                state_next     = S_DONE;
                case (req_reg.req_type)
                    plir_pkg::REQ_READ:
                    begin
                        if (pos_ok_rd)
                        begin
                            ram.re         = 1'b1;
                            ram.raddr      = pos_addr;
                            head_pend_next = 1'b1;
                            state_next     = S_SHIFT;
                        end
                        else
                        begin
                            status_next = plir_pkg::ST_BADPOS;
                        end
                    end

                    plir_pkg::REQ_INSERT:
                    begin
                        if (full)
                        begin
                            status_next = plir_pkg::ST_FULL;
                        end
                        else if (!pos_ok_ins)
                        begin
                            status_next = plir_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            // Entries count-1 down to pos-1 each move up one slot.
                            rd_addr_next = plir_pkg::addr_t'(count_reg - plir_pkg::cnt_t'(1));
                            wr_addr_next = plir_pkg::addr_t'(count_reg);
                            rd_left_next = count_reg - plir_pkg::cnt_t'(pos)
                                           + plir_pkg::cnt_t'(1);
                            up_next      = 1'b0;
                            state_next   = S_SHIFT;
                        end
                    end

                    plir_pkg::REQ_REMOVE:
                    begin
                        if (pos_ok_rd)
                        begin
                            // Fetch the removed entry, then pull later ones down.
                            ram.re         = 1'b1;
                            ram.raddr      = pos_addr;
                            head_pend_next = 1'b1;
                            rd_addr_next   = plir_pkg::addr_t'(pos);
                            wr_addr_next   = pos_addr;
                            rd_left_next   = count_reg - plir_pkg::cnt_t'(pos);
                            up_next        = 1'b1;
                            state_next     = S_SHIFT;
                        end
                        else
                        begin
                            status_next = plir_pkg::ST_BADPOS;
                        end
                    end

                    default:
                    begin
                        status_next = plir_pkg::ST_BADPOS;
                    end
                endcase
            end

            S_SHIFT:
            begin
                head_pend_next = 1'b0;
                if (head_pend_reg)
                begin
                    value_next = rdata;
                end
                // Data read last cycle is written one slot over. The read and
                // write addresses are always two apart, so they never collide.
                if (wr_pend_reg)
                begin
                    ram.we       = 1'b1;
                    ram.waddr    = wr_addr_reg;
                    ram.wdata    = rdata;
                    wr_addr_next = up_reg ? wr_addr_reg + plir_pkg::addr_t'(1)
                                          : wr_addr_reg - plir_pkg::addr_t'(1);
                end
                if (rd_left_reg != '0)
                begin
                    ram.re       = 1'b1;
                    ram.raddr    = rd_addr_reg;
                    rd_addr_next = up_reg ? rd_addr_reg + plir_pkg::addr_t'(1)
                                          : rd_addr_reg - plir_pkg::addr_t'(1);
                    rd_left_next = rd_left_reg - plir_pkg::cnt_t'(1);
                    wr_pend_next = 1'b1;
                end
                else
                begin
                    wr_pend_next = 1'b0;
                end
                if (!head_pend_reg && !wr_pend_reg && (rd_left_reg == '0))
                begin
                    if (req_reg.req_type == plir_pkg::REQ_INSERT)
                    begin
                        ram.we     = 1'b1;
                        ram.waddr  = pos_addr;
                        ram.wdata  = req_reg.value_in;
                        count_next = count_reg + plir_pkg::cnt_t'(1);
                    end
                    else if (req_reg.req_type == plir_pkg::REQ_REMOVE)
                    begin
                        count_next = count_reg - plir_pkg::cnt_t'(1);
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (rsp_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_left_reg   <= '0;
            wr_pend_reg   <= 1'b0;
            head_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_left_reg   <= rd_left_next;
            wr_pend_reg   <= wr_pend_next;
            head_pend_reg <= head_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        rd_addr_reg <= rd_addr_next;
        wr_addr_reg <= wr_addr_next;
        up_reg      <= up_next;
        value_reg   <= value_next;
        status_reg  <= status_next;
    end

    assign req_stall        = (state_reg != S_IDLE);
    assign done             = (state_reg == S_DONE);
    assign result.value_out = value_reg;
    assign result.status    = status_reg;
    assign result.count     = count_reg;
    assign result.is_empty  = (count_reg == '0);

endmodule
